// ===== rtl/core/ssd_pkg.sv =====
`default_nettype none

package ssd_pkg;

    // Display geometry
    localparam int NUM_POSITIONS = 5;
    localparam int POS_W         = 3;
    localparam int CODE_W        = 5;
    localparam int SEG_W         = 8;
    localparam int SEL_W         = 5;

    // Default depth of the command queue between front and back
    localparam int SSD_QUEUE_DEPTH = 4;

    // Operation codes carried on the input tuser
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SHOW = 2'd1;
    localparam logic [1:0] OP_RAW  = 2'd2;

    // Special glyph codes and marker values
    localparam logic [CODE_W-1:0] GLYPH_BLANK = 5'd16;
    localparam logic [CODE_W-1:0] GLYPH_MINUS = 5'd18;
    localparam logic [POS_W-1:0]  DOT_NONE    = 3'd5;
    localparam logic [POS_W-1:0]  LAST_POS    = 3'd4;
    localparam logic [2:0]        DOTS_MAX    = 3'd4;
    localparam logic [SEG_W-1:0]  DP_BIT      = 8'h80;
    localparam logic [SEL_W-1:0]  SEL_NONE    = 5'h1F;

    // Show-integer range limits
    localparam logic [15:0] POS_LIMIT = 16'd9999;
    localparam logic [15:0] NEG_LIMIT = 16'd999;

    // Command kinds handed from front to back
    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_LOAD,
        CMD_NONE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                    kind;
        logic                         invalid;
        logic [3:0][CODE_W-1:0]       codes;   // index 0 = ones position
        logic [POS_W-1:0]             dot;
        logic [2:0]                   dots;
    } cmd_t;

    // 20-entry font, codes past the end show blank
    function automatic logic [SEG_W-1:0] glyph(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] seg;
        case (code)
            5'd0:    seg = 8'h3F;
            5'd1:    seg = 8'h06;
            5'd2:    seg = 8'h5B;
            5'd3:    seg = 8'h4F;
            5'd4:    seg = 8'h66;
            5'd5:    seg = 8'h6D;
            5'd6:    seg = 8'h7D;
            5'd7:    seg = 8'h27;
            5'd8:    seg = 8'h7F;
            5'd9:    seg = 8'h6F;
            5'd10:   seg = 8'h77;
            5'd11:   seg = 8'h7C;
            5'd12:   seg = 8'h39;
            5'd13:   seg = 8'h5E;
            5'd14:   seg = 8'h79;
            5'd15:   seg = 8'h71;
            5'd17:   seg = 8'hFF;
            5'd18:   seg = 8'h40;
            5'd19:   seg = 8'h76;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    // Active-low select per position; the dots position drives bit 4
    function automatic logic [SEL_W-1:0] select_line(input logic [POS_W-1:0] pos);
        logic [SEL_W-1:0] sel;
        case (pos)
            3'd0:    sel = 5'h17;
            3'd1:    sel = 5'h1B;
            3'd2:    sel = 5'h1D;
            3'd3:    sel = 5'h1E;
            3'd4:    sel = 5'h0F;
            default: sel = 5'h17;
        endcase
        return sel;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ssd_front.sv =====
`default_nettype none

module ssd_front (
    input  wire logic [1:0]                   op,
    input  wire logic [15:0]                  number,
    input  wire logic [ssd_pkg::CODE_W-1:0]   code_ones,
    input  wire logic [ssd_pkg::CODE_W-1:0]   code_tens,
    input  wire logic [ssd_pkg::CODE_W-1:0]   code_hundreds,
    input  wire logic [ssd_pkg::CODE_W-1:0]   code_thousands,
    input  wire logic [ssd_pkg::POS_W-1:0]    dot_position,
    input  wire logic [2:0]                   dots_pattern,
    output ssd_pkg::cmd_t                     cmd
);
    import ssd_pkg::*;

    logic        neg;
    logic [15:0] abs_val;
    logic        out_of_range;
    logic [13:0] mag;
    logic [29:0] prod10;
    logic [26:0] prod100;
    logic [27:0] prod1000;
    logic [9:0]  q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
    logic [3:0]  d0, d1, d2, d3;
    logic [CODE_W-1:0] c1, c2, c3;

    // Magnitude and range check
    assign neg          = number[15];
    assign abs_val      = neg ? (16'd0 - number) : number;
    assign out_of_range = neg ? (abs_val > NEG_LIMIT) : (abs_val > POS_LIMIT);
    assign mag          = abs_val[13:0];

    // Decimal digits by reciprocal multiplication, exact for values below 10000
    assign prod10   = 30'(mag) * 30'd52429;
    assign prod100  = 27'(mag) * 27'd5243;
    assign prod1000 = 28'(mag) * 28'd8389;
    assign q10      = prod10[28:19];
    assign q100     = prod100[25:19];
    assign q1000    = prod1000[26:23];

    assign d0 = 4'(mag - 14'(q10) * 14'd10);
    assign d1 = 4'(q10 - 10'(q100) * 10'd10);
    assign d2 = 4'(q100 - 7'(q1000) * 7'd10);
    assign d3 = q1000;

    // Leading-zero blanking, minus sign in the leftmost position
    assign c1 = (mag >= 14'd10)   ? CODE_W'(d1) : GLYPH_BLANK;
    assign c2 = (mag >= 14'd100)  ? CODE_W'(d2) : GLYPH_BLANK;
    assign c3 = (mag >= 14'd1000) ? CODE_W'(d3) : (neg ? GLYPH_MINUS : GLYPH_BLANK);

    // Classify the beat
    always_comb begin
        cmd.kind    = CMD_NONE;
        cmd.invalid = 1'b0;
        cmd.codes   = {code_thousands, code_hundreds, code_tens, code_ones};
        cmd.dot     = dot_position;
        cmd.dots    = dots_pattern;
        case (op)
            OP_TICK: begin
                cmd.kind = CMD_TICK;
            end
            OP_SHOW: begin
                if (out_of_range) begin
                    cmd.invalid = 1'b1;
                end else begin
                    cmd.kind  = CMD_LOAD;
                    cmd.codes = {c3, c2, c1, CODE_W'(d0)};
                    cmd.dot   = DOT_NONE;
                    cmd.dots  = 3'd0;
                end
            end
            OP_RAW: begin
                cmd.kind = CMD_LOAD;
            end
            default: begin
                cmd.kind = CMD_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/ssd_queue.sv =====
`default_nettype none

module ssd_queue #(
    parameter int DEPTH = ssd_pkg::SSD_QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire ssd_pkg::cmd_t  push_cmd,
    output logic                full,
    input  wire logic           pop,
    output ssd_pkg::cmd_t       pop_cmd,
    output logic                not_empty
);
    import ssd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entries_reg[rd_ptr_reg];

    // Pointer and fill-count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ssd_back.sv =====
`default_nettype none

module ssd_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cmd_valid,
    input  wire ssd_pkg::cmd_t               cmd,
    output logic                             cmd_pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [ssd_pkg::SEL_W-1:0]        out_select,
    output logic [ssd_pkg::SEG_W-1:0]        out_segments,
    output logic                             out_invalid
);
    import ssd_pkg::*;

    logic [SEG_W-1:0] patterns_reg [NUM_POSITIONS];
    logic [SEG_W-1:0] patterns_next [NUM_POSITIONS];
    logic [POS_W-1:0] scan_reg, scan_next, scan_eff;
    logic             valid_reg, valid_next;
    logic [SEL_W-1:0] sel_reg, sel_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic             inv_reg, inv_next;

    assign cmd_pop      = cmd_valid && (!valid_reg || out_ready);
    assign out_valid    = valid_reg;
    assign out_select   = sel_reg;
    assign out_segments = seg_reg;
    assign out_invalid  = inv_reg;

    assign scan_eff = (scan_reg > LAST_POS) ? '0 : scan_reg;

    // Execute one command per popped beat
    always_comb begin
        patterns_next = patterns_reg;
        scan_next     = scan_reg;
        valid_next    = valid_reg && !out_ready;
        sel_next      = sel_reg;
        seg_next      = seg_reg;
        inv_next      = inv_reg;
        if (cmd_pop) begin
            valid_next = 1'b1;
            sel_next   = SEL_NONE;
            seg_next   = '0;
            inv_next   = cmd.invalid;
            case (cmd.kind)
                CMD_TICK: begin
                    sel_next  = select_line(scan_eff);
                    seg_next  = patterns_reg[scan_eff];
                    scan_next = (scan_eff == LAST_POS) ? '0 : scan_eff + 1'b1;
                end
                CMD_LOAD: begin
                    for (int i = 0; i < 4; i++) begin
                        patterns_next[i] = glyph(cmd.codes[i]);
                    end
                    patterns_next[NUM_POSITIONS-1] =
                        (cmd.dots <= DOTS_MAX) ? SEG_W'(cmd.dots) : '0;
                    for (int i = 0; i < NUM_POSITIONS; i++) begin
                        if (cmd.dot == POS_W'(i)) begin
                            patterns_next[i] = patterns_next[i] | DP_BIT;
                        end
                    end
                end
                default: begin
                    sel_next = SEL_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_POSITIONS; i++) begin
                patterns_reg[i] <= '0;
            end
            scan_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            patterns_reg <= patterns_next;
            scan_reg     <= scan_next;
            valid_reg    <= valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        sel_reg <= sel_next;
        seg_reg <= seg_next;
        inv_reg <= inv_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/seven_segment_mux_display.sv =====
// Driver for a four-digit multiplexed seven-segment display plus a fifth
// position for indicator dots. Every input beat gives exactly one output beat,
// in order. The beat kind travels on s_axis_tuser: a scan tick returns the
// active-low select and segment byte of the current position and moves to the
// next one; a show-integer beat loads a signed decimal number (leading zeros
// blanked, minus sign leftmost, range -999 to 9999, otherwise the display is
// kept and tuser of the result flags it); a raw beat loads four font codes, a
// decimal-point position and a dots pattern. Loads return select 0x1F and
// segments 0. The block takes one beat per clock when the output is drained;
// a result passes a queue entry and then the output register: decoding and
// decimal conversion happen on entry, a small command queue (QUEUE_DEPTH
// beats) absorbs output stalls, and the executing stage holds the result in
// an output register.
`default_nettype none

module seven_segment_mux_display #(
    parameter int QUEUE_DEPTH = ssd_pkg::SSD_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // number[15:0], code_ones[20:16], code_tens[25:21], code_hundreds[30:26],
    // code_thousands[35:31], dot_position[38:36], dots_pattern[41:39], zeros
    input  wire logic [47:0] s_axis_tdata,
    // operation[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // select_n[4:0], segments[12:5], zeros
    output logic [15:0]      m_axis_tdata,
    // invalid[0]
    output logic [0:0]       m_axis_tuser
);
    import ssd_pkg::*;

    cmd_t             front_cmd;
    cmd_t             queue_cmd;
    logic             queue_full;
    logic             queue_valid;
    logic             queue_pop;
    logic             push;
    logic [SEL_W-1:0] res_select;
    logic [SEG_W-1:0] res_segments;
    logic             res_invalid;

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && s_axis_tready;

    // Decode and decimal conversion
    ssd_front u_front (
        .op             (s_axis_tuser),
        .number         (s_axis_tdata[15:0]),
        .code_ones      (s_axis_tdata[20:16]),
        .code_tens      (s_axis_tdata[25:21]),
        .code_hundreds  (s_axis_tdata[30:26]),
        .code_thousands (s_axis_tdata[35:31]),
        .dot_position   (s_axis_tdata[38:36]),
        .dots_pattern   (s_axis_tdata[41:39]),
        .cmd            (front_cmd)
    );

    // Command queue
    ssd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_cmd   (queue_cmd),
        .not_empty (queue_valid)
    );

    // Display state and result register
    ssd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (queue_valid),
        .cmd          (queue_cmd),
        .cmd_pop      (queue_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_select   (res_select),
        .out_segments (res_segments),
        .out_invalid  (res_invalid)
    );

    assign m_axis_tdata = {3'b000, res_segments, res_select};
    assign m_axis_tuser = res_invalid;

endmodule

`default_nettype wire
